### rtl/core/weighted_theme_color_sampler_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the theme color sampler
// Implication checks on the block's internal logic; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_THEME_COLOR_SAMPLER_TOP_ASSERT_SVH
`define WEIGHTED_THEME_COLOR_SAMPLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define WTCS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("wtcs: same-cycle check failed");

`define WTCS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("wtcs: next-cycle check failed");

`else

`define WTCS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons)

`define WTCS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons)

`endif

`endif

### rtl/core/wtcs_pkg.sv
// ----------------------------------------------------------------------------
// Theme color sampler package
// Field widths, register indexes and the serial divider control types.
// ----------------------------------------------------------------------------
package wtcs_pkg;

    localparam int CH_W       = 8;
    localparam int STRIDE_W   = 16;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STRIDE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_COLOR = 8'd1;

    // serial divider: dividend is left aligned, steps = quotient bits to produce
    localparam int DVD_W  = 49;
    localparam int DVS_W  = 32;
    localparam int STEP_W = 6;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/core/wtcs_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// One RGBA pixel per transfer, with an end-of-image mark.
// ----------------------------------------------------------------------------
interface wtcs_pix_if
    import wtcs_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;

    modport source (output valid, red, green, blue, alpha, last, input ready);
    modport sink   (input valid, red, green, blue, alpha, last, output ready);
endinterface

### rtl/core/wtcs_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// One theme color per image.
// ----------------------------------------------------------------------------
interface wtcs_res_if
    import wtcs_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] theme_red;
    logic [CH_W-1:0] theme_green;
    logic [CH_W-1:0] theme_blue;
    logic            found;

    modport source (output valid, theme_red, theme_green, theme_blue, found, input ready);
    modport sink   (input valid, theme_red, theme_green, theme_blue, found, output ready);
endinterface

### rtl/core/wtcs_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data, one register per transfer.
// ----------------------------------------------------------------------------
interface wtcs_cfg_if
    import wtcs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/wtcs_sdiv.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------------
module wtcs_sdiv
    import wtcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  dvd_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVD_W-1:0]  quo_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    // bring down the next dividend bit and try one subtract
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### rtl/core/weighted_theme_color_sampler_top.sv
// ----------------------------------------------------------------------------
// Weighted theme color sampler
// Subsamples an RGBA image, gathers plain and weighted color sums and gives
// one readable theme color at the end of each image.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  pix      in   valid/ready   red, green, blue, alpha, last
//  res      out  valid/ready   theme_red, theme_green, theme_blue, found
//  cfg      in   valid/ready   index, data (0 sample_stride, 1 fallback_color)
//
//  a skipped or low-alpha pixel only advances the stride phase; a kept one runs
//  a luma divide and, inside the luma window, a saturation divide and the weight
//  steps; end of image runs a weighted or plain mean divide per channel, then the luma of the mean
//  reset clears the sums, the stride phase and the result register
//  a finished result waits in the output register while new pixels go in
// ----------------------------------------------------------------------------
`include "weighted_theme_color_sampler_top_assert.svh"

module weighted_theme_color_sampler_top
    import wtcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wtcs_pix_if.sink    pix,
    wtcs_res_if.source  res,
    wtcs_cfg_if.sink    cfg
);

    localparam int PSUM_W      = 32;
    localparam int WSUM_W      = 48;
    localparam int WT_W        = 32;
    localparam int CNT_W       = 24;
    localparam int Q16_W       = 16;
    localparam int W_W         = 17;
    localparam int LUMA_NUM_W  = 25;
    localparam int PLAIN_NUM_W = 33;

    localparam logic [STEP_W-1:0] LUMA_STEPS  = 6'd25;
    localparam logic [STEP_W-1:0] SAT_STEPS   = 6'd24;
    localparam logic [STEP_W-1:0] PLAIN_STEPS = 6'd33;
    localparam logic [STEP_W-1:0] WMEAN_STEPS = 6'd49;

    localparam logic [CH_W-1:0]  ALPHA_MIN  = 8'd64;
    localparam logic [Q16_W-1:0] LUMA_LO    = 16'd6554;
    localparam logic [Q16_W-1:0] LUMA_HI    = 16'd60293;
    localparam logic [Q16_W-1:0] LUMA_MID   = 16'd34079;
    localparam logic [Q16_W-1:0] LUMA_DARK  = 16'd22282;
    localparam logic [Q16_W-1:0] LUMA_LIGHT = 16'd48497;
    localparam logic [WT_W-1:0]  WT_MIN     = 32'd65;
    localparam logic [W_W-1:0]   T1_BASE    = 17'd13107;
    localparam logic [W_W-1:0]   SAT_GAIN   = 17'd117965;
    localparam logic [W_W-1:0]   T2_ONE     = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LUMA_GO,
        S_LUMA_WAIT,
        S_SAT_WAIT,
        S_TERMS,
        S_W1,
        S_W2,
        S_ACC,
        S_FINAL,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_RLUMA_GO,
        S_RLUMA_WAIT,
        S_EMIT
    } state_t;

    function automatic logic [LUMA_NUM_W-1:0] luma_num(
        input logic [CH_W-1:0] r,
        input logic [CH_W-1:0] g,
        input logic [CH_W-1:0] b
    );
        return LUMA_NUM_W'(r) * LUMA_NUM_W'(19595) + LUMA_NUM_W'(g) * LUMA_NUM_W'(38470)
             + LUMA_NUM_W'(b) * LUMA_NUM_W'(7471) + LUMA_NUM_W'(127);
    endfunction

    function automatic logic [PSUM_W-1:0] add_sat32(
        input logic [PSUM_W-1:0] a,
        input logic [PSUM_W-1:0] b
    );
        logic [PSUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PSUM_W] ? '1 : s[PSUM_W-1:0];
    endfunction

    function automatic logic [WSUM_W-1:0] add_sat48(
        input logic [WSUM_W-1:0] a,
        input logic [WSUM_W-1:0] b
    );
        logic [WSUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WSUM_W] ? '1 : s[WSUM_W-1:0];
    endfunction

    // lighten dark colors toward white, darken bright ones toward black
    function automatic logic [CH_W-1:0] readable(
        input logic [CH_W-1:0]  c,
        input logic [Q16_W-1:0] luma
    );
        logic [22:0] lift;
        logic [22:0] drop;
        lift = 23'(CH_W'(8'd255) - c) * 23'(15729) + 23'(32768);
        drop = 23'(c) * 23'(14418) + 23'(32768);
        if (luma < LUMA_DARK)
            return c + CH_W'(lift[22:16]);
        else if (luma > LUMA_LIGHT)
            return c - CH_W'(drop[22:16]);
        else
            return c;
    endfunction

    // configuration
    logic [STRIDE_W-1:0] stride_reg;
    logic [COLOR_W-1:0]  fallback_reg;
    logic [STRIDE_W-1:0] stride_eff;

    // image state
    state_t              state_reg, state_next;
    logic [STRIDE_W-1:0] phase_reg, phase_next;
    logic [WSUM_W-1:0]   wsum_reg [3];
    logic [WSUM_W-1:0]   wsum_next [3];
    logic [WT_W-1:0]     weight_total_reg, weight_total_next;
    logic [PSUM_W-1:0]   psum_reg [3];
    logic [PSUM_W-1:0]   psum_next [3];
    logic [CNT_W-1:0]    plain_count_reg, plain_count_next;
    logic [1:0]          ch_reg, ch_next;
    logic                use_w_reg, use_w_next;
    logic                found_reg, found_next;

    // per pixel working registers
    logic [CH_W-1:0]     px_red_reg, px_red_next;
    logic [CH_W-1:0]     px_green_reg, px_green_next;
    logic [CH_W-1:0]     px_blue_reg, px_blue_next;
    logic [CH_W-1:0]     px_alpha_reg, px_alpha_next;
    logic                px_last_reg, px_last_next;
    logic [Q16_W-1:0]    luma_reg, luma_next;
    logic [Q16_W-1:0]    sat_reg, sat_next;
    logic [W_W-1:0]      t1_reg, t1_next;
    logic [W_W-1:0]      t2_reg, t2_next;
    logic [W_W-1:0]      p1_reg, p1_next;
    logic [W_W-1:0]      w_reg, w_next;
    logic [CH_W-1:0]     c_reg [3];
    logic [CH_W-1:0]     c_next [3];
    logic [Q16_W-1:0]    rluma_reg, rluma_next;

    // result register
    logic                res_valid_reg, res_valid_next;
    logic [CH_W-1:0]     res_red_reg, res_red_next;
    logic [CH_W-1:0]     res_green_reg, res_green_next;
    logic [CH_W-1:0]     res_blue_reg, res_blue_next;
    logic                res_found_reg, res_found_next;

    // divider hookup
    div_ctl_t            div_ctl;
    div_stat_t           div_stat;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [DVD_W-1:0]    div_quo;

    logic                pix_fire;
    logic                kept;
    logic                emit_go;
    logic [CH_W-1:0]     hi_val;
    logic [CH_W-1:0]     lo_val;
    logic [Q16_W-1:0]    luma_q;
    logic [CH_W-1:0]     mean_q;
    logic [Q16_W-1:0]    luma_dist;
    logic [32:0]         t1_prod;
    logic [32:0]         p1_prod;
    logic [33:0]         w_prod;
    logic [Q16_W-1:0]    alpha_q16;
    logic                image_clear;
    logic                idle_with_res;

    wtcs_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign cfg.ready = 1'b1;
    assign pix.ready = (state_reg == S_IDLE);
    assign pix_fire  = pix.valid && pix.ready;
    assign stride_eff = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
    assign kept = (phase_reg == '0);

    assign res.valid       = res_valid_reg;
    assign res.theme_red   = res_red_reg;
    assign res.theme_green = res_green_reg;
    assign res.theme_blue  = res_blue_reg;
    assign res.found       = res_found_reg;

    always_comb
    begin
        hi_val = px_red_reg;
        lo_val = px_red_reg;
        if (px_green_reg > hi_val) hi_val = px_green_reg;
        if (px_blue_reg > hi_val) hi_val = px_blue_reg;
        if (px_green_reg < lo_val) lo_val = px_green_reg;
        if (px_blue_reg < lo_val) lo_val = px_blue_reg;
    end

    assign luma_q = (|div_quo[DVD_W-1:Q16_W]) ? '1 : div_quo[Q16_W-1:0];
    assign mean_q = (|div_quo[DVD_W-1:CH_W]) ? '1 : div_quo[CH_W-1:0];

    assign luma_dist = (luma_reg > LUMA_MID) ? (luma_reg - LUMA_MID) : (LUMA_MID - luma_reg);
    assign alpha_q16 = {px_alpha_reg, px_alpha_reg};    // alpha * 257
    assign t1_prod   = 33'(SAT_GAIN) * 33'(sat_reg);
    assign p1_prod   = 33'(alpha_q16) * 33'(t1_reg);
    assign w_prod    = 34'(p1_reg) * 34'(t2_reg);

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        wsum_next         = wsum_reg;
        weight_total_next = weight_total_reg;
        psum_next         = psum_reg;
        plain_count_next  = plain_count_reg;
        ch_next           = ch_reg;
        use_w_next        = use_w_reg;
        found_next        = found_reg;
        px_red_next       = px_red_reg;
        px_green_next     = px_green_reg;
        px_blue_next      = px_blue_reg;
        px_alpha_next     = px_alpha_reg;
        px_last_next      = px_last_reg;
        luma_next         = luma_reg;
        sat_next          = sat_reg;
        t1_next           = t1_reg;
        t2_next           = t2_reg;
        p1_next           = p1_reg;
        w_next            = w_reg;
        c_next            = c_reg;
        rluma_next        = rluma_reg;
        res_valid_next    = res_valid_reg;
        res_red_next      = res_red_reg;
        res_green_next    = res_green_reg;
        res_blue_next     = res_blue_reg;
        res_found_next    = res_found_reg;
        div_ctl           = '0;
        div_dividend      = '0;
        div_divisor       = '0;
        emit_go           = 1'b0;

        if (res.valid && res.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (pix_fire)
                begin
                    px_red_next   = pix.red;
                    px_green_next = pix.green;
                    px_blue_next  = pix.blue;
                    px_alpha_next = pix.alpha;
                    px_last_next  = pix.last;
                    // a phase at or past the end of the stride wraps to zero
                    if (phase_reg >= stride_eff - 1'b1)
                        phase_next = '0;
                    else
                        phase_next = phase_reg + 1'b1;
                    if (kept && pix.alpha >= ALPHA_MIN)
                    begin
                        psum_next[0] = add_sat32(psum_reg[0], PSUM_W'(pix.red));
                        psum_next[1] = add_sat32(psum_reg[1], PSUM_W'(pix.green));
                        psum_next[2] = add_sat32(psum_reg[2], PSUM_W'(pix.blue));
                        if (plain_count_reg != '1)
                            plain_count_next = plain_count_reg + 1'b1;
                        state_next = S_LUMA_GO;
                    end
                    else if (pix.last)
                        state_next = S_FINAL;
                end
            end

            S_LUMA_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = LUMA_STEPS;
                div_dividend  = {luma_num(px_red_reg, px_green_reg, px_blue_reg),
                                 {(DVD_W-LUMA_NUM_W){1'b0}}};
                div_divisor   = DVS_W'(255);
                state_next    = S_LUMA_WAIT;
            end

            S_LUMA_WAIT:
            begin
                if (div_stat.done)
                begin
                    luma_next = luma_q;
                    if (luma_q >= LUMA_LO && luma_q <= LUMA_HI)
                    begin
                        if (hi_val == '0)
                        begin
                            sat_next   = '0;
                            state_next = S_TERMS;
                        end
                        else
                        begin
                            div_ctl.start = 1'b1;
                            div_ctl.steps = SAT_STEPS;
                            div_dividend  = {CH_W'(hi_val - lo_val), {(DVD_W-CH_W){1'b0}}};
                            div_divisor   = DVS_W'(hi_val);
                            state_next    = S_SAT_WAIT;
                        end
                    end
                    else
                        state_next = px_last_reg ? S_FINAL : S_IDLE;
                end
            end

            S_SAT_WAIT:
            begin
                if (div_stat.done)
                begin
                    sat_next   = luma_q;
                    state_next = S_TERMS;
                end
            end

            S_TERMS:
            begin
                t1_next    = T1_BASE + W_W'(t1_prod[32:16]);
                t2_next    = T2_ONE - W_W'(luma_dist);
                state_next = S_W1;
            end

            S_W1:
            begin
                p1_next    = p1_prod[32:16];
                state_next = S_W2;
            end

            S_W2:
            begin
                w_next     = w_prod[32:16];
                state_next = S_ACC;
            end

            S_ACC:
            begin
                wsum_next[0] = add_sat48(wsum_reg[0], WSUM_W'(px_red_reg) * WSUM_W'(w_reg));
                wsum_next[1] = add_sat48(wsum_reg[1], WSUM_W'(px_green_reg) * WSUM_W'(w_reg));
                wsum_next[2] = add_sat48(wsum_reg[2], WSUM_W'(px_blue_reg) * WSUM_W'(w_reg));
                weight_total_next = add_sat32(weight_total_reg, WT_W'(w_reg));
                state_next = px_last_reg ? S_FINAL : S_IDLE;
            end

            S_FINAL:
            begin
                ch_next = '0;
                if (weight_total_reg > WT_MIN)
                begin
                    use_w_next = 1'b1;
                    found_next = 1'b1;
                    state_next = S_MEAN_GO;
                end
                else if (plain_count_reg != '0)
                begin
                    use_w_next = 1'b0;
                    found_next = 1'b1;
                    state_next = S_MEAN_GO;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_EMIT;
                end
            end

            S_MEAN_GO:
            begin
                div_ctl.start = 1'b1;
                // rounded mean: (sum + n/2) / n
                if (use_w_reg)
                begin
                    div_ctl.steps = WMEAN_STEPS;
                    div_dividend  = DVD_W'(wsum_reg[ch_reg]) + DVD_W'(weight_total_reg >> 1);
                    div_divisor   = weight_total_reg;
                end
                else
                begin
                    div_ctl.steps = PLAIN_STEPS;
                    div_dividend  = {PLAIN_NUM_W'(psum_reg[ch_reg])
                                     + PLAIN_NUM_W'(plain_count_reg >> 1),
                                     {(DVD_W-PLAIN_NUM_W){1'b0}}};
                    div_divisor   = DVS_W'(plain_count_reg);
                end
                state_next = S_MEAN_WAIT;
            end

            S_MEAN_WAIT:
            begin
                if (div_stat.done)
                begin
                    c_next[ch_reg] = mean_q;
                    if (ch_reg == 2'd2)
                        state_next = S_RLUMA_GO;
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_MEAN_GO;
                    end
                end
            end

            S_RLUMA_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = LUMA_STEPS;
                div_dividend  = {luma_num(c_reg[0], c_reg[1], c_reg[2]),
                                 {(DVD_W-LUMA_NUM_W){1'b0}}};
                div_divisor   = DVS_W'(255);
                state_next    = S_RLUMA_WAIT;
            end

            S_RLUMA_WAIT:
            begin
                if (div_stat.done)
                begin
                    rluma_next = luma_q;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // wait until the result register is free
                if (!res_valid_reg || res.ready)
                begin
                    emit_go        = 1'b1;
                    res_valid_next = 1'b1;
                    res_found_next = found_reg;
                    if (found_reg)
                    begin
                        res_red_next   = readable(c_reg[0], rluma_reg);
                        res_green_next = readable(c_reg[1], rluma_reg);
                        res_blue_next  = readable(c_reg[2], rluma_reg);
                    end
                    else
                    begin
                        res_red_next   = fallback_reg[23:16];
                        res_green_next = fallback_reg[15:8];
                        res_blue_next  = fallback_reg[7:0];
                    end
                    phase_next        = '0;
                    wsum_next[0]      = '0;
                    wsum_next[1]      = '0;
                    wsum_next[2]      = '0;
                    weight_total_next = '0;
                    psum_next[0]      = '0;
                    psum_next[1]      = '0;
                    psum_next[2]      = '0;
                    plain_count_next  = '0;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            stride_reg       <= STRIDE_W'(1);
            fallback_reg     <= '0;
            phase_reg        <= '0;
            wsum_reg[0]      <= '0;
            wsum_reg[1]      <= '0;
            wsum_reg[2]      <= '0;
            weight_total_reg <= '0;
            psum_reg[0]      <= '0;
            psum_reg[1]      <= '0;
            psum_reg[2]      <= '0;
            plain_count_reg  <= '0;
            ch_reg           <= '0;
            use_w_reg        <= 1'b0;
            found_reg        <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_red_reg      <= '0;
            res_green_reg    <= '0;
            res_blue_reg     <= '0;
            res_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            wsum_reg         <= wsum_next;
            weight_total_reg <= weight_total_next;
            psum_reg         <= psum_next;
            plain_count_reg  <= plain_count_next;
            ch_reg           <= ch_next;
            use_w_reg        <= use_w_next;
            found_reg        <= found_next;
            res_valid_reg    <= res_valid_next;
            res_red_reg      <= res_red_next;
            res_green_reg    <= res_green_next;
            res_blue_reg     <= res_blue_next;
            res_found_reg    <= res_found_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SAMPLE_STRIDE:  stride_reg   <= cfg.data[STRIDE_W-1:0];
                    REG_FALLBACK_COLOR: fallback_reg <= cfg.data[COLOR_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_red_reg   <= px_red_next;
        px_green_reg <= px_green_next;
        px_blue_reg  <= px_blue_next;
        px_alpha_reg <= px_alpha_next;
        px_last_reg  <= px_last_next;
        luma_reg     <= luma_next;
        sat_reg      <= sat_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        p1_reg       <= p1_next;
        w_reg        <= w_next;
        c_reg        <= c_next;
        rluma_reg    <= rluma_next;
    end

    assign image_clear   = (plain_count_reg == '0) && (weight_total_reg == '0)
                        && (phase_reg == '0);
    assign idle_with_res = res_valid_reg && (state_reg == S_IDLE);

    // the divider is only restarted once it has finished
    `WTCS_ASSERT_IMP(a_div_no_restart, clk, rst_n, div_ctl.start, !div_stat.busy)
    // every weighted pixel was also counted in the plain sum
    `WTCS_ASSERT_IMP(a_weight_needs_count, clk, rst_n, |weight_total_reg, |plain_count_reg)
    // a result clears the image state and returns to idle
    `WTCS_ASSERT_NXT(a_clear_after_emit, clk, rst_n, emit_go, image_clear)
    `WTCS_ASSERT_NXT(a_result_follows_emit, clk, rst_n, emit_go, idle_with_res)

endmodule

### test/weighted_theme_color_sampler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Theme color sampler testbench
// Streams RGBA images through the sampler with random gaps on both channels,
// predicts each image's theme color in a local fixed-point model and compares
// every result field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module weighted_theme_color_sampler_top_tb;
    import wtcs_pkg::*;

    localparam int SETTLE_CYCLES    = 300;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int RANDOM_ITEMS     = 800;

    // indexes the block has no register for
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hFF;

    localparam logic [63:0] MAX24        = 64'hFF_FFFF;
    localparam logic [63:0] MAX32        = 64'hFFFF_FFFF;
    localparam logic [63:0] MAX48        = 64'hFFFF_FFFF_FFFF;
    localparam logic [7:0]  ALPHA_MIN    = 8'd64;
    localparam logic [63:0] LUMA_WIN_LO  = 64'd6554;
    localparam logic [63:0] LUMA_WIN_HI  = 64'd60293;
    localparam logic [63:0] LUMA_MID     = 64'd34079;
    localparam logic [63:0] LUMA_DARK    = 64'd22282;
    localparam logic [63:0] LUMA_BRIGHT  = 64'd48497;
    localparam logic [63:0] WEIGHT_FLOOR = 64'd65;

    typedef enum {TONE_ANY, TONE_DARK, TONE_BRIGHT, TONE_CLEAR, TONE_VIVID, TONE_GREY} tone_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       found;
    } theme_t;

    logic clk = 1'b0;
    logic rst_n;

    wtcs_pix_if pix_if ();
    wtcs_res_if res_if ();
    wtcs_cfg_if cfg_if ();

    weighted_theme_color_sampler_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // local copy of the block's registers and image sums
    logic [15:0] cur_stride;
    logic [23:0] fallback;
    logic [15:0] phase;
    logic [63:0] wsum [3];
    logic [63:0] psum [3];
    logic [63:0] wtotal;
    logic [63:0] pcount;

    theme_t expected_themes [$];
    int     errors = 0;
    int     pixels_counted = 0;
    bit     no_idle = 1'b0;
    bit     hold_active = 1'b0;
    int     long_holds_asked = 0;
    int     long_holds_done = 0;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, b, limit);
        logic [63:0] s;
        s = a + b;
        return (s > limit) ? limit : s;
    endfunction

    function automatic logic [63:0] luma_of(input logic [63:0] r, g, b);
        logic [63:0] l;
        l = (64'd19595 * r + 64'd38470 * g + 64'd7471 * b + 64'd127) / 64'd255;
        return (l > 64'd65535) ? 64'd65535 : l;
    endfunction

    function automatic logic [63:0] mean_code(input logic [63:0] sum, n);
        logic [63:0] m;
        m = (sum + n / 2) / n;
        return (m > 64'd255) ? 64'd255 : m;
    endfunction

    function automatic void clear_image_sums();
        phase  = '0;
        wtotal = '0;
        pcount = '0;
        for (int i = 0; i < 3; i++)
        begin
            wsum[i] = '0;
            psum[i] = '0;
        end
    endfunction

    function automatic pixel_t pix_of(input logic [7:0] r, g, b, a, input logic last);
        pixel_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.alpha = a;
        p.last  = last;
        return p;
    endfunction

    function automatic pixel_t random_pixel(input tone_t tone);
        pixel_t p;
        int     pick;
        p.red   = 8'($urandom);
        p.green = 8'($urandom);
        p.blue  = 8'($urandom);
        p.alpha = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(64, 255));
        p.last  = 1'b0;
        case (tone)
            TONE_DARK:
            begin
                p.red   = 8'($urandom_range(0, 70));
                p.green = 8'($urandom_range(0, 70));
                p.blue  = 8'($urandom_range(0, 70));
            end
            TONE_BRIGHT:
            begin
                p.red   = 8'($urandom_range(190, 255));
                p.green = 8'($urandom_range(190, 255));
                p.blue  = 8'($urandom_range(190, 255));
            end
            TONE_CLEAR:
                p.alpha = 8'($urandom_range(0, 63));
            TONE_VIVID:
            begin
                pick    = $urandom_range(0, 2);
                p.red   = (pick == 0) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 40));
                p.green = (pick == 1) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 40));
                p.blue  = (pick == 2) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 40));
            end
            TONE_GREY:
            begin
                p.green = p.red;
                p.blue  = p.red;
            end
            default:
                p.last = 1'b0;
        endcase
        return p;
    endfunction

    // update the image sums with one accepted pixel; on the last one queue
    // the theme color the block must give
    task automatic fold_pixel(input pixel_t p);
        logic [16:0] eff;
        logic [63:0] rgb [3];
        logic [63:0] c [3];
        logic [63:0] lum, sat, hi, lo, t1, off_mid, t2, w;
        bit          kept;
        theme_t      t;
        rgb[0] = p.red;
        rgb[1] = p.green;
        rgb[2] = p.blue;
        eff = (cur_stride == 16'd0) ? 17'd1 : {1'b0, cur_stride};
        kept = (phase == 16'd0);
        // a phase at or past the end of the stride, also a shortened one, wraps to zero
        if ({1'b0, phase} >= eff - 17'd1)
            phase = '0;
        else
            phase = phase + 16'd1;
        if (kept && p.alpha >= ALPHA_MIN)
        begin
            lum = luma_of(rgb[0], rgb[1], rgb[2]);
            for (int i = 0; i < 3; i++)
                psum[i] = sat_add(psum[i], rgb[i], MAX32);
            pcount = sat_add(pcount, 64'd1, MAX24);
            if (lum >= LUMA_WIN_LO && lum <= LUMA_WIN_HI)
            begin
                hi = rgb[0];
                lo = rgb[0];
                for (int i = 1; i < 3; i++)
                begin
                    if (rgb[i] > hi)
                        hi = rgb[i];
                    if (rgb[i] < lo)
                        lo = rgb[i];
                end
                sat = (hi == 0) ? 64'd0 : ((hi - lo) << 16) / hi;
                if (sat > 64'd65535)
                    sat = 64'd65535;
                t1 = 64'd13107 + ((64'd117965 * sat) >> 16);
                off_mid = (lum > LUMA_MID) ? lum - LUMA_MID : LUMA_MID - lum;
                t2 = 64'd65536 - off_mid;
                w = ((((64'(p.alpha) * 64'd257) * t1) >> 16) * t2) >> 16;
                for (int i = 0; i < 3; i++)
                    wsum[i] = sat_add(wsum[i], rgb[i] * w, MAX48);
                wtotal = sat_add(wtotal, w, MAX32);
            end
        end
        if (p.last)
        begin
            if (wtotal > WEIGHT_FLOOR || pcount != 0)
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = (wtotal > WEIGHT_FLOOR) ? mean_code(wsum[i], wtotal)
                                                   : mean_code(psum[i], pcount);
                lum = luma_of(c[0], c[1], c[2]);
                for (int i = 0; i < 3; i++)
                begin
                    if (lum < LUMA_DARK)
                        c[i] = c[i] + (((64'd255 - c[i]) * 64'd15729 + 64'd32768) >> 16);
                    else if (lum > LUMA_BRIGHT)
                        c[i] = c[i] - ((c[i] * 64'd14418 + 64'd32768) >> 16);
                end
                t = '{red: c[0][7:0], green: c[1][7:0], blue: c[2][7:0], found: 1'b1};
            end
            else
            begin
                // fallback goes out as written, not lightened or darkened
                t = '{red: fallback[23:16], green: fallback[15:8], blue: fallback[7:0],
                      found: 1'b0};
            end
            expected_themes = {expected_themes, t};
            clear_image_sums();
        end
    endtask

    // valid is left high after a transfer so that a back-to-back pixel never
    // sees it dropped and raised in the same step
    task automatic send_pixel(input pixel_t p);
        int gap;
        gap = no_idle ? 0 : idle_gap();
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.red   <= p.red;
        pix_if.green <= p.green;
        pix_if.blue  <= p.blue;
        pix_if.alpha <= p.alpha;
        pix_if.last  <= p.last;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        fold_pixel(p);
        pixels_counted++;
    endtask

    task automatic send_image(input int len, input tone_t tone);
        pixel_t p;
        for (int i = 0; i < len; i++)
        begin
            p = random_pixel(($urandom_range(0, 3) == 0) ? TONE_ANY : tone);
            p.last = (i == len - 1);
            send_pixel(p);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        // let a write issued in this same step drop valid first
        if (cfg_if.valid)
            @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == REG_SAMPLE_STRIDE)
            cur_stride = value[15:0];
        else if (idx == REG_FALLBACK_COLOR)
            fallback = value;
    endtask

    // all results in, then time for a pixel still being folded in
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (expected_themes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_pixel(pix_of(8'd200, 8'd100, 8'd50, 8'd255, 1'b1));
        send_pixel(pix_of(8'd10, 8'd20, 8'd30, 8'd0, 1'b1));
        wait_idle();
    endtask

    task automatic test_pixel_extremes();
        // black and white fall outside the luma window
        send_pixel(pix_of(8'd0, 8'd0, 8'd0, 8'd255, 1'b1));
        send_pixel(pix_of(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        send_pixel(pix_of(8'd255, 8'd0, 8'd0, 8'd64, 1'b0));
        send_pixel(pix_of(8'd0, 8'd255, 8'd0, 8'd128, 1'b0));
        send_pixel(pix_of(8'd0, 8'd0, 8'd255, 8'd255, 1'b0));
        send_pixel(pix_of(8'd40, 8'd40, 8'd40, 8'd63, 1'b1));
        send_pixel(pix_of(8'd128, 8'd128, 8'd128, 8'd255, 1'b1));
        send_pixel(pix_of(8'd255, 8'd255, 8'd255, 8'd63, 1'b1));
        wait_idle();
    endtask

    task automatic test_registers();
        write_reg(REG_FALLBACK_COLOR, 24'hFFFFFF);
        write_reg(REG_SPARE_FIRST, 24'h123456);
        write_reg(REG_SPARE_LAST, 24'hFFFFFF);
        send_pixel(pix_of(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        wait_idle();

        // zero stride keeps every pixel
        write_reg(REG_SAMPLE_STRIDE, 24'h000000);
        write_reg(REG_FALLBACK_COLOR, 24'h5AA5C3);
        send_pixel(pix_of(8'd250, 8'd10, 8'd10, 8'd255, 1'b0));
        send_pixel(pix_of(8'd10, 8'd10, 8'd250, 8'd255, 1'b1));
        wait_idle();

        // upper data bits do not reach the stride
        write_reg(REG_SAMPLE_STRIDE, 24'hFFFFFF);
        send_pixel(pix_of(8'd20, 8'd30, 8'd60, 8'd255, 1'b0));
        send_pixel(pix_of(8'd250, 8'd250, 8'd250, 8'd255, 1'b0));
        send_pixel(pix_of(8'd240, 8'd120, 8'd0, 8'd255, 1'b0));
        send_pixel(pix_of(8'd255, 8'd255, 8'd0, 8'd255, 1'b1));
        wait_idle();

        // last pixel off phase is dropped, next image restarts at phase 0
        write_reg(REG_SAMPLE_STRIDE, 24'd3);
        send_pixel(pix_of(8'd90, 8'd160, 8'd30, 8'd255, 1'b0));
        send_pixel(pix_of(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        send_pixel(pix_of(8'd30, 8'd60, 8'd200, 8'd200, 1'b1));
        wait_idle();

        // shorten the stride in the middle of an image
        write_reg(REG_SAMPLE_STRIDE, 24'd5);
        send_pixel(pix_of(8'd180, 8'd90, 8'd40, 8'd255, 1'b0));
        send_pixel(pix_of(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        send_pixel(pix_of(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
        wait_idle();
        write_reg(REG_SAMPLE_STRIDE, 24'd2);
        send_pixel(pix_of(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(pix_of(8'd60, 8'd140, 8'd220, 8'd160, 1'b1));
        wait_idle();
    endtask

    task automatic test_result_backpressure();
        write_reg(REG_SAMPLE_STRIDE, 24'd1);
        long_holds_asked++;
        while (!hold_active)
            @(posedge clk);
        // results pile up until the pixel input stalls
        no_idle = 1'b1;
        repeat (4) send_image(3, TONE_ANY);
        no_idle = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_images();
        int          r;
        int          len;
        logic [15:0] stride;
        logic [23:0] color;
        pixels_counted = 0;
        while (pixels_counted < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 19);
            if (r < 10)
                stride = 16'd1;
            else if (r < 16)
                stride = 16'($urandom_range(2, 4));
            else if (r < 19)
                stride = 16'($urandom_range(5, 16));
            else
                stride = 16'($urandom_range(100, 300));
            write_reg(REG_SAMPLE_STRIDE, {8'($urandom), stride});
            r = $urandom_range(0, 9);
            color = (r == 0) ? 24'h000000 : (r == 1) ? 24'hFFFFFF : 24'($urandom);
            write_reg(REG_FALLBACK_COLOR, color);
            repeat ($urandom_range(3, 8))
            begin
                r = $urandom_range(0, 19);
                if (r < 15)
                    len = $urandom_range(1, 12);
                else if (r < 19)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(60, 120);
                send_image(len, tone_t'($urandom_range(0, 5)));
            end
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // result side ready, with short and long stalls and one long hold-off
    initial
    begin : ready_driver
        int gap;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_holds_asked != long_holds_done)
            begin
                res_if.ready <= 1'b0;
                hold_active = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                long_holds_done++;
            end
            else
            begin
                res_if.ready <= 1'b1;
                repeat (no_idle ? 16 : $urandom_range(1, 24)) @(posedge clk);
                gap = no_idle ? 0 : idle_gap();
                if (gap > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (gap - 1) @(posedge clk);
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want, got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        theme_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_themes.size() == 0)
            begin
                $display("%0t: unexpected result transfer, rgb %0d %0d %0d found %0d", $time,
                         res_if.theme_red, res_if.theme_green, res_if.theme_blue,
                         res_if.found);
                errors++;
            end
            else
            begin
                want = expected_themes.pop_front();
                check_field("theme_red", want.red, res_if.theme_red);
                check_field("theme_green", want.green, res_if.theme_green);
                check_field("theme_blue", want.blue, res_if.theme_blue);
                check_field("found", 8'(want.found), 8'(res_if.found));
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.red   <= '0;
        pix_if.green <= '0;
        pix_if.blue  <= '0;
        pix_if.alpha <= '0;
        pix_if.last  <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        cur_stride = 16'd1;
        fallback   = '0;
        clear_image_sums();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_pixel_extremes();
        test_registers();
        test_result_backpressure();
        test_random_images();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
